// ===== hdl/mam_pkg.sv =====
// Shared types and constants of the matrix audio mixer.
package mam_pkg;

  localparam int NUM_IN   = 4;
  localparam int NUM_OUT  = 8;
  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 16;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 5;
  localparam int CH_W     = 3;
  localparam int MUTE_W   = 8;

  localparam int OSEL_W    = $clog2(NUM_OUT);
  localparam int ISEL_W    = $clog2(NUM_IN);
  localparam int MIX_SLOTS = NUM_IN * NUM_OUT;

  // Datapath widths: sample times zero-extended gain, then sum of all inputs
  localparam int PROD_W      = SAMPLE_W + COEF_W + 1;
  localparam int ACC_W       = PROD_W + ISEL_W;
  localparam int MAG_W       = ACC_W - 1;
  localparam int FULL_W      = MAG_W + COEF_W;
  localparam int SCALE_SHIFT = 2 * (COEF_W - 1);
  localparam int QUO_W       = FULL_W - SCALE_SHIFT;

  localparam logic [COEF_W-1:0] UNITY = {1'b1, {(COEF_W-1){1'b0}}};

  // Item kinds on the input channel
  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MIX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FADER = 2'd2;

  // Operations held in the queue between front and back
  typedef enum logic [1:0] {
    OP_FRAME,
    OP_MIX,
    OP_FADER
  } op_t;

  typedef struct packed {
    op_t                              op;
    logic [NUM_IN-1:0][SAMPLE_W-1:0]  samples;
    logic [IDX_W-1:0]                 idx;
    logic [COEF_W-1:0]                coef;
  } q_entry_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            mute;
  } tag_t;

endpackage

// ===== hdl/mam_in_if.sv =====
// Input channel of the mixer: frames and gain writes.
interface mam_in_if;
  logic                                valid;
  logic                                ready;
  logic [mam_pkg::KIND_W-1:0]          kind;
  logic signed [mam_pkg::SAMPLE_W-1:0] in_sample_0;
  logic signed [mam_pkg::SAMPLE_W-1:0] in_sample_1;
  logic signed [mam_pkg::SAMPLE_W-1:0] in_sample_2;
  logic signed [mam_pkg::SAMPLE_W-1:0] in_sample_3;
  logic [mam_pkg::IDX_W-1:0]           target_index;
  logic [mam_pkg::COEF_W-1:0]          coefficient;

  modport source (output valid, kind, in_sample_0, in_sample_1, in_sample_2, in_sample_3,
                  target_index, coefficient, input ready);
  modport sink   (input valid, kind, in_sample_0, in_sample_1, in_sample_2, in_sample_3,
                  target_index, coefficient, output ready);
endinterface

// ===== hdl/mam_out_if.sv =====
// Result channel of the mixer: one mixed sample per transaction.
interface mam_out_if;
  logic                                valid;
  logic                                ready;
  logic [mam_pkg::CH_W-1:0]            channel;
  logic signed [mam_pkg::SAMPLE_W-1:0] out_sample;
  logic                                clipped;
  logic                                last;

  modport source (output valid, channel, out_sample, clipped, last, input ready);
  modport sink   (input valid, channel, out_sample, clipped, last, output ready);
endinterface

// ===== hdl/mam_cfg_if.sv =====
// Configuration channel of the mixer: writes the mute mask.
interface mam_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mam_pkg::MUTE_W-1:0] mute_mask;

  modport source (output valid, mute_mask, input ready);
  modport sink   (input valid, mute_mask, output ready);
endinterface

// ===== hdl/matrix_audio_mixer.sv =====
// Top level of the 4-in, 8-out matrix audio mixer.
// Usage:
//   in_ch carries one item per transaction: a sample frame (four signed 32-bit
//   samples), a mix gain write (slot input*8+output) or a fader gain write.
//   Gains are unsigned Q1.15; values above unity are clamped to unity.
//   out_ch gives eight transactions per frame, channels 0..7 in order, with
//   last set on channel 7. cfg_ch writes the 8-bit mute mask; write it only
//   while no frame is in flight.
// Timing:
//   The back-end sequencer gives a frame's outputs one per cycle while out_ch
//   is ready; a gain write is applied as soon as it reaches the queue head.
//   The first result of a frame passes through the queue, then four pipeline
//   stages into the output register, and the rest follow one per cycle while
//   out_ch is ready.
//   The front end accepts items into a QUEUE_DEPTH-entry queue while the back
//   end works, so the next frame is taken while results still drain.
// Reset and stall:
//   Synchronous reset clears gains, mute mask, queue and pipeline.
//   A stalled out_ch freezes the pipeline; the queue then fills and in_ch
//   ready drops. No result is lost or repeated.
module matrix_audio_mixer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  mam_in_if.sink   in_ch,
  mam_out_if.source out_ch,
  mam_cfg_if.sink  cfg_ch
);

  logic                       push;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  mam_pkg::q_entry_t          push_data;
  mam_pkg::q_entry_t          q_head;
  logic [mam_pkg::MUTE_W-1:0] mute_mask_r;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_mask_r <= '0;
    end else if (cfg_ch.valid) begin
      mute_mask_r <= cfg_ch.mute_mask;
    end
  end

  mam_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .entry  (push_data)
  );

  mam_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  mam_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .mute_mask (mute_mask_r),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/mam_front.sv =====
// Front end: accepts input transactions, clamps gains and drops void items.
module mam_front (
  mam_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output mam_pkg::q_entry_t  entry
);

  logic keep;

  // Take a transaction whenever the queue has room
  assign in_ch.ready = !q_full;

  // Classify the item and build the queue entry
  always_comb begin
    entry.op         = mam_pkg::OP_FRAME;
    entry.samples[0] = in_ch.in_sample_0;
    entry.samples[1] = in_ch.in_sample_1;
    entry.samples[2] = in_ch.in_sample_2;
    entry.samples[3] = in_ch.in_sample_3;
    entry.idx        = in_ch.target_index;
    entry.coef       = (in_ch.coefficient > mam_pkg::UNITY) ? mam_pkg::UNITY
                                                            : in_ch.coefficient;
    keep             = 1'b0;
    unique case (in_ch.kind)
      mam_pkg::KIND_FRAME: begin
        entry.op = mam_pkg::OP_FRAME;
        keep     = 1'b1;
      end
      mam_pkg::KIND_MIX: begin
        entry.op = mam_pkg::OP_MIX;
        keep     = {1'b0, in_ch.target_index} < (mam_pkg::IDX_W+1)'(mam_pkg::MIX_SLOTS);
      end
      mam_pkg::KIND_FADER: begin
        entry.op = mam_pkg::OP_FADER;
        keep     = {1'b0, in_ch.target_index} < (mam_pkg::IDX_W+1)'(mam_pkg::NUM_OUT);
      end
      default: begin
        // drop the unused kind
        keep = 1'b0;
      end
    endcase
    push = in_ch.valid && in_ch.ready && keep;
  end

endmodule

// ===== hdl/mam_queue.sv =====
// Short queue of classified items between front and back.
module mam_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mam_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mam_pkg::q_entry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  mam_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/mam_back.sv =====
// Back end: holds the gains, sequences outputs and runs the mix pipeline.
module mam_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  mam_pkg::q_entry_t          q_head,
  output logic                       q_pop,
  input  logic [mam_pkg::MUTE_W-1:0] mute_mask,
  mam_out_if.source                  out_ch
);

  localparam int NI     = mam_pkg::NUM_IN;
  localparam int NO     = mam_pkg::NUM_OUT;
  localparam int OSEL_W = mam_pkg::OSEL_W;
  localparam int ISEL_W = mam_pkg::ISEL_W;
  localparam int COEF_W = mam_pkg::COEF_W;
  localparam int SMP_W  = mam_pkg::SAMPLE_W;
  localparam int PROD_W = mam_pkg::PROD_W;
  localparam int ACC_W  = mam_pkg::ACC_W;
  localparam int MAG_W  = mam_pkg::MAG_W;
  localparam int FULL_W = mam_pkg::FULL_W;
  localparam int QUO_W  = mam_pkg::QUO_W;
  localparam logic [OSEL_W-1:0] LAST_OUT = OSEL_W'(NO - 1);
  localparam logic [QUO_W-1:0]  POS_LIM  = QUO_W'((64'd1 << (SMP_W - 1)) - 64'd1);
  localparam logic [QUO_W-1:0]  NEG_LIM  = QUO_W'(64'd1 << (SMP_W - 1));
  localparam logic [SMP_W-1:0]  POS_MAX  = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0]  NEG_MIN  = {1'b1, {(SMP_W-1){1'b0}}};

  // Mix gain banks, one per input, each indexed by output; fader gains by output
  logic [COEF_W-1:0] mix_gain_r   [NI][NO];
  logic [COEF_W-1:0] fader_gain_r [NO];

  logic [OSEL_W-1:0] out_idx_r;
  logic              adv;
  logic              issue;
  logic              head_frame;

  // Pipeline stages
  logic                     s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  mam_pkg::tag_t            s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic [COEF_W-1:0]        s1_fader_r, s2_fader_r, s3_fader_r;
  logic signed [PROD_W-1:0] s1_prod_r [NI];
  logic signed [ACC_W-1:0]  s2_acc_r;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [ACC_W-1:0]         abs_val;
  logic                     s3_neg_r, s4_neg_r;
  logic [MAG_W-1:0]         s3_mag_r;
  logic [FULL_W-1:0]        s4_full_r;
  logic [QUO_W-1:0]         quo;

  // Output register
  logic                     out_valid_r;
  logic [mam_pkg::CH_W-1:0] out_ch_r;
  logic [SMP_W-1:0]         out_sample_r;
  logic                     out_clip_r;
  logic                     out_last_r;
  logic [SMP_W-1:0]         sample_nxt;
  logic                     clip_nxt;

  // Pipeline advances unless a finished result is stalled
  assign adv        = !out_valid_r || out_ch.ready;
  assign head_frame = (q_head.op == mam_pkg::OP_FRAME);
  assign issue      = q_valid && head_frame && adv;
  assign q_pop      = q_valid && (!head_frame || (issue && out_idx_r == LAST_OUT));

  // Apply gain writes as they leave the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NI; i++) begin
        for (int o = 0; o < NO; o++) begin
          mix_gain_r[i][o] <= '0;
        end
      end
      for (int o = 0; o < NO; o++) begin
        fader_gain_r[o] <= '0;
      end
    end else if (q_valid) begin
      case (q_head.op)
        mam_pkg::OP_MIX: begin
          mix_gain_r[q_head.idx[OSEL_W +: ISEL_W]][q_head.idx[OSEL_W-1:0]] <= q_head.coef;
        end
        mam_pkg::OP_FADER: begin
          fader_gain_r[q_head.idx[OSEL_W-1:0]] <= q_head.coef;
        end
        default: begin
        end
      endcase
    end
  end

  // Step through the outputs of the current frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_idx_r <= '0;
    end else if (issue) begin
      out_idx_r <= (out_idx_r == LAST_OUT) ? '0 : out_idx_r + 1'b1;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // Sum the weighted inputs and take the magnitude
  always_comb begin
    acc_sum = '0;
    for (int i = 0; i < NI; i++) begin
      acc_sum = acc_sum + ACC_W'(s1_prod_r[i]);
    end
    abs_val = s2_acc_r[ACC_W-1] ? -s2_acc_r : s2_acc_r;
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // weight each input by its mix gain
      for (int i = 0; i < NI; i++) begin
        s1_prod_r[i] <= PROD_W'($signed(q_head.samples[i]) *
                                $signed({1'b0, mix_gain_r[i][out_idx_r]}));
      end
      s1_fader_r    <= fader_gain_r[out_idx_r];
      s1_tag_r.ch   <= mam_pkg::CH_W'(out_idx_r);
      s1_tag_r.last <= (out_idx_r == LAST_OUT);
      s1_tag_r.mute <= mute_mask[out_idx_r];
      // accumulate
      s2_acc_r   <= acc_sum;
      s2_fader_r <= s1_fader_r;
      s2_tag_r   <= s1_tag_r;
      // sign and magnitude
      s3_neg_r   <= s2_acc_r[ACC_W-1];
      s3_mag_r   <= abs_val[MAG_W-1:0];
      s3_fader_r <= s2_fader_r;
      s3_tag_r   <= s2_tag_r;
      // scale by the fader
      s4_full_r  <= s3_mag_r * s3_fader_r;
      s4_neg_r   <= s3_neg_r;
      s4_tag_r   <= s3_tag_r;
    end
  end

  // Truncate, saturate and mute
  always_comb begin
    quo        = s4_full_r[FULL_W-1:mam_pkg::SCALE_SHIFT];
    sample_nxt = '0;
    clip_nxt   = 1'b0;
    if (!s4_tag_r.mute) begin
      if (s4_neg_r) begin
        if (quo > NEG_LIM) begin
          sample_nxt = NEG_MIN;
          clip_nxt   = 1'b1;
        end else begin
          sample_nxt = -quo[SMP_W-1:0];
        end
      end else begin
        if (quo > POS_LIM) begin
          sample_nxt = POS_MAX;
          clip_nxt   = 1'b1;
        end else begin
          sample_nxt = quo[SMP_W-1:0];
        end
      end
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch_r     <= s4_tag_r.ch;
      out_last_r   <= s4_tag_r.last;
      out_sample_r <= sample_nxt;
      out_clip_r   <= clip_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.channel    = out_ch_r;
  assign out_ch.out_sample = out_sample_r;
  assign out_ch.clipped    = out_clip_r;
  assign out_ch.last       = out_last_r;

endmodule
